// ===== design/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// apsp_pkg
// Item types, function codes and status codes for the all-pairs shortest
// path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_RUN  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [1:0] STATUS_LOAD = 2'd0;
    localparam logic [1:0] STATUS_RUN  = 2'd1;
    localparam logic [1:0] STATUS_READ = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] weight;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] distance;
        logic        no_path;
    } rsp_item_t;

endpackage

// ===== design/apsp_ram.sv =====
// ----------------------------------------------------------------------------
// apsp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module apsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/all_pairs_shortest_path.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall distance matrix held in RAM: load, in-place run, read.
// ----------------------------------------------------------------------------
// Load/read items: one accepted per cycle while busy is low; each is registered
// in stage 1, then its result in the done/rsp output registers. Run item: busy
// throughout, one relaxation step per cycle on a pair of mirrored RAMs (one read
// port each), plus a fetch step per row for the (i,k) entry; done strobes in
// the first cycle with busy low. Reset clears the sequencer and output strobe;
// the matrix is undefined until loaded. Results cannot be stalled by the receiver.
module all_pairs_shortest_path #(
    parameter int NODES       = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  apsp_pkg::cmd_item_t   cmd,
    output logic                  done,
    output apsp_pkg::rsp_item_t   rsp
);

    import apsp_pkg::*;

    localparam int W     = WEIGHT_BITS;
    localparam int IW    = $clog2(NODES);
    localparam int DEPTH = NODES * NODES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [W-1:0]  NOEDGE = '1;
    localparam logic [IW-1:0] LAST   = IW'(NODES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_READ     = 3'd1;
    localparam logic [2:0] OP_READ_OUT = 3'd2;
    localparam logic [2:0] OP_IK       = 3'd3;
    localparam logic [2:0] OP_RELAX    = 3'd4;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic          phase_reg, phase_next;

    logic          s1_valid_reg, s1_valid_next;
    logic [2:0]    s1_op_reg, s1_op_next;
    logic [AW-1:0] s1_addr_reg, s1_addr_next;
    logic [W-1:0]  ik_reg, ik_next;

    logic          done_reg, done_next;
    rsp_item_t     rsp_reg, rsp_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [W-1:0]  wdata;
    logic [AW-1:0] raddr_a, raddr_b;
    logic [W-1:0]  rdata_a, rdata_b;

    logic          accept;
    logic          in_range;
    logic [AW-1:0] cmd_addr;
    logic [W-1:0]  load_value;
    logic [W-1:0]  via;
    logic [W:0]    sum;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                                input logic [IW-1:0] c);
        return AW'(AW'(r) * AW'(NODES) + AW'(c));
    endfunction

    assign accept   = start && !busy;
    assign in_range = (32'(cmd.row) < NODES) && (32'(cmd.col) < NODES);
    assign cmd_addr = cell_addr(IW'(cmd.row), IW'(cmd.col));

    // Clamp load weights above the no-edge code.
    always_comb
    begin
        if (32'(cmd.weight) > 32'(NOEDGE))
        begin
            load_value = NOEDGE;
        end
        else
        begin
            load_value = W'(cmd.weight);
        end
    end

    // Saturating path through k: ik_reg plus d[k][j] from port A.
    assign sum = {1'b0, ik_reg} + {1'b0, rdata_a};
    always_comb
    begin
        if (ik_reg == NOEDGE || rdata_a == NOEDGE || sum >= {1'b0, NOEDGE})
        begin
            via = NOEDGE;
        end
        else
        begin
            via = sum[W-1:0];
        end
    end

    // Sequencer and read issue.
    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        phase_next    = phase_reg;
        s1_valid_next = 1'b0;
        s1_op_next    = s1_op_reg;
        s1_addr_next  = s1_addr_reg;
        raddr_a       = cell_addr(i_reg, k_reg);
        raddr_b       = cmd_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    s1_addr_next = cmd_addr;
                    priority if (cmd.func == FUNC_LOAD)
                    begin
                        s1_valid_next = 1'b1;
                        s1_op_next    = OP_LOAD;
                    end
                    else if (cmd.func == FUNC_READ)
                    begin
                        s1_valid_next = 1'b1;
                        s1_op_next    = in_range ? OP_READ : OP_READ_OUT;
                    end
                    else if (cmd.func == FUNC_RUN)
                    begin
                        state_next = ST_RUN;
                        k_next     = '0;
                        i_next     = '0;
                        j_next     = '0;
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        s1_valid_next = 1'b0;
                    end
                end
            end
            ST_RUN:
            begin
                s1_valid_next = 1'b1;
                if (!phase_reg)
                begin
                    // Fetch d[i][k] for the row about to stream.
                    raddr_a    = cell_addr(i_reg, k_reg);
                    s1_op_next = OP_IK;
                    phase_next = 1'b1;
                    j_next     = '0;
                end
                else
                begin
                    raddr_a      = cell_addr(k_reg, j_reg);
                    raddr_b      = cell_addr(i_reg, j_reg);
                    s1_op_next   = OP_RELAX;
                    s1_addr_next = cell_addr(i_reg, j_reg);
                    if (j_reg == LAST)
                    begin
                        j_next     = '0;
                        phase_next = 1'b0;
                        if (i_reg == LAST)
                        begin
                            i_next = '0;
                            if (k_reg == LAST)
                            begin
                                k_next     = '0;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                k_next = k_reg + IW'(1);
                            end
                        end
                        else
                        begin
                            i_next = i_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IW'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Stage 1: RAM data is back; write back, capture ik, or form the result.
    always_comb
    begin
        we        = 1'b0;
        waddr     = cmd_addr;
        wdata     = load_value;
        ik_next   = ik_reg;
        done_next = 1'b0;
        rsp_next  = '0;

        if (accept && cmd.func == FUNC_LOAD && in_range)
        begin
            we = 1'b1;
        end

        if (s1_valid_reg)
        begin
            unique case (s1_op_reg)
                OP_LOAD:
                begin
                    done_next       = 1'b1;
                    rsp_next.status = STATUS_LOAD;
                end
                OP_READ:
                begin
                    done_next         = 1'b1;
                    rsp_next.status   = STATUS_READ;
                    rsp_next.distance = 16'(rdata_b);
                    rsp_next.no_path  = (rdata_b == NOEDGE);
                end
                OP_READ_OUT:
                begin
                    done_next         = 1'b1;
                    rsp_next.status   = STATUS_READ;
                    rsp_next.distance = 16'(NOEDGE);
                    rsp_next.no_path  = 1'b1;
                end
                OP_IK:
                begin
                    ik_next = rdata_a;
                end
                OP_RELAX:
                begin
                    // Replace only on a strictly shorter path.
                    if (via < rdata_b)
                    begin
                        we    = 1'b1;
                        waddr = s1_addr_reg;
                        wdata = via;
                    end
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end

        if (state_reg == ST_FINISH)
        begin
            done_next       = 1'b1;
            rsp_next.status = STATUS_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            phase_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= OP_LOAD;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            phase_reg    <= phase_next;
            s1_valid_reg <= s1_valid_next;
            s1_op_reg    <= s1_op_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= s1_addr_next;
        ik_reg      <= ik_next;
        rsp_reg     <= rsp_next;
    end

    // Two mirrored copies give the relaxation step two read ports.
    apsp_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    apsp_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_run_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == STATUS_RUN |-> $past(state_reg == ST_FINISH))
        else $error("run result without a finished run");

    a_relax_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_op_reg == OP_RELAX |-> busy)
        else $error("relaxation write-back outside a run");

    a_run_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == FUNC_RUN |=> busy)
        else $error("run item did not occupy the block");

    a_no_path_distance: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.no_path |-> rsp.distance == 16'(NOEDGE))
        else $error("no-path result with a finite distance");

endmodule

// ===== tb/apsp_distance_checker.sv =====
// ----------------------------------------------------------------------------
// apsp_distance_checker
// Watches the command and response ports of the all-pairs shortest path
// block, keeps its own copy of the distance matrix, predicts every answer and
// compares each strobed response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module apsp_distance_checker
    import apsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  cmd_item_t cmd,
    input  logic      done,
    input  rsp_item_t rsp,
    output int        mismatches,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NODES  = 16;
    localparam logic [15:0] NOEDGE = 16'hFFFF;

    logic [15:0] dist_mat [NODES*NODES];
    rsp_item_t   predicted_answers [$];
    int          error_tally = 0;

    // Path through an intermediate node; no edge on either leg means no path.
    function automatic logic [15:0] via_sum(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        if (a == NOEDGE || b == NOEDGE)
            return NOEDGE;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, NOEDGE}) ? NOEDGE : s[15:0];
    endfunction

    task automatic relax_all_pairs();
        logic [15:0] ik;
        logic [15:0] via;
        for (int k = 0; k < NODES; k++)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                ik = dist_mat[i*NODES + k];
                for (int j = 0; j < NODES; j++)
                begin
                    via = via_sum(ik, dist_mat[k*NODES + j]);
                    if (via < dist_mat[i*NODES + j])
                        dist_mat[i*NODES + j] = via;
                end
            end
        end
    endtask

    task automatic note_error(input string what, input rsp_item_t exp_r, input rsp_item_t got_r);
        error_tally++;
        if (error_tally <= 10)
            $display({"%0t mismatch (%s): expected status %0d distance %0d no_path %0b,",
                      " got status %0d distance %0d no_path %0b"},
                     $time, what, exp_r.status, exp_r.distance, exp_r.no_path,
                     got_r.status, got_r.distance, got_r.no_path);
    endtask

    always @(posedge clk)
    begin
        rsp_item_t exp_r;
        rsp_item_t ans;
        if (rst_n)
        begin
            if (done)
            begin
                if (predicted_answers.size() == 0)
                begin
                    note_error("result with nothing pending", '0, rsp);
                end
                else
                begin
                    exp_r = predicted_answers.pop_front();
                    if (rsp.status !== exp_r.status || rsp.distance !== exp_r.distance ||
                        rsp.no_path !== exp_r.no_path)
                        note_error("wrong field", exp_r, rsp);
                end
            end

            if (start && !busy)
            begin
                ans = '0;
                case (cmd.func)
                    FUNC_LOAD:
                    begin
                        dist_mat[{cmd.row, cmd.col}] = cmd.weight;
                        ans.status = STATUS_LOAD;
                        predicted_answers.push_back(ans);
                    end
                    FUNC_RUN:
                    begin
                        relax_all_pairs();
                        ans.status = STATUS_RUN;
                        predicted_answers.push_back(ans);
                    end
                    FUNC_READ:
                    begin
                        ans.status   = STATUS_READ;
                        ans.distance = dist_mat[{cmd.row, cmd.col}];
                        ans.no_path  = (ans.distance == NOEDGE);
                        predicted_answers.push_back(ans);
                    end
                    default:
                    begin
                        // unknown function: no effect, no answer
                    end
                endcase
            end
        end
        mismatches  <= error_tally;
        outstanding <= predicted_answers.size();
    end

endmodule

// ===== tb/all_pairs_shortest_path_tb.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_tb
// Loads a full distance matrix, runs directed corner items (zero and no-edge
// weights, saturating sums, unknown function), then a long random mix of
// loads, reads, relaxation runs and unknown functions with random start gaps. Answers are
// checked by a separate checker instance.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_tb;
    import apsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NODES           = 16;
    localparam logic [15:0] NOEDGE          = 16'hFFFF;
    localparam logic [1:0]  FUNC_UNUSED     = 2'd3;
    localparam int          RANDOM_ITEMS    = 1040;
    localparam int          MAX_RANDOM_RUNS = 50;
    localparam int          CALM_ITEMS      = 150;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          RUN_CYCLES      = NODES*NODES*(NODES+1) + 1;
    localparam int          CYCLE_LIMIT     =
        4 * ((MAX_RANDOM_RUNS + 4) * (RUN_CYCLES + 4) +
             (RANDOM_ITEMS + 2*NODES*NODES + 40) * 8) + 1000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    cmd_item_t cmd;
    logic      done;
    rsp_item_t rsp;
    int        mismatches;
    int        outstanding;
    int        cycle_count = 0;

    always #1 clk = ~clk;

    all_pairs_shortest_path u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    apsp_distance_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic cmd_item_t make_item(input logic [1:0] f, input logic [3:0] r,
                                            input logic [3:0] c, input logic [15:0] w);
        cmd_item_t it;
        it.func   = f;
        it.row    = r;
        it.col    = c;
        it.weight = w;
        return it;
    endfunction

    // Weights lean toward no-edge and short hops so paths form, with some
    // near-saturation values to exercise the saturating sum.
    function automatic logic [15:0] pick_weight();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 16'd0;
        else if (sel <= 6)
            return NOEDGE;
        else if (sel <= 12)
            return 16'($urandom_range(1, 20));
        else if (sel <= 15)
            return 16'($urandom_range(30000, 65534));
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // Hold start until accepted, then maybe drop it for a short burst.
    task automatic send(input cmd_item_t it, input bit calm);
        int gap;
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            cmd   <= make_item(2'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int  sel;
        int  runs_done;
        int  sent;
        bit  calm;

        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write every entry before anything reads or relaxes
        for (int r = 0; r < NODES; r++)
        begin
            for (int c = 0; c < NODES; c++)
            begin
                send(make_item(FUNC_LOAD, 4'(r), 4'(c),
                               (r == c && $urandom_range(0, 1) == 1) ? 16'd0 : pick_weight()),
                     1'b0);
            end
        end

        // corners: weight extremes, saturating sum, no-edge legs, unknown function
        send(make_item(FUNC_LOAD, 4'd0, 4'd0, 16'd0), 1'b0);
        send(make_item(FUNC_LOAD, 4'd15, 4'd15, NOEDGE), 1'b0);
        send(make_item(FUNC_LOAD, 4'd0, 4'd15, 16'd65534), 1'b0);
        send(make_item(FUNC_LOAD, 4'd15, 4'd0, 16'd1), 1'b0);
        send(make_item(FUNC_READ, 4'd0, 4'd0, 16'd0), 1'b0);
        send(make_item(FUNC_READ, 4'd15, 4'd15, NOEDGE), 1'b0);
        send(make_item(FUNC_READ, 4'd0, 4'd15, 16'd0), 1'b0);
        send(make_item(FUNC_READ, 4'd15, 4'd0, NOEDGE), 1'b0);
        send(make_item(FUNC_UNUSED, 4'd15, 4'd15, NOEDGE), 1'b0);
        send(make_item(FUNC_LOAD, 4'd3, 4'd5, 16'd65000), 1'b0);
        send(make_item(FUNC_LOAD, 4'd5, 4'd7, 16'd1000), 1'b0);
        send(make_item(FUNC_LOAD, 4'd3, 4'd7, NOEDGE), 1'b0);
        send(make_item(FUNC_LOAD, 4'd4, 4'd6, NOEDGE), 1'b0);
        send(make_item(FUNC_LOAD, 4'd6, 4'd8, 16'd5), 1'b0);
        send(make_item(FUNC_LOAD, 4'd4, 4'd8, NOEDGE), 1'b0);
        send(make_item(FUNC_RUN, 4'd0, 4'd0, 16'd0), 1'b0);
        send(make_item(FUNC_READ, 4'd3, 4'd7, 16'd0), 1'b0);
        send(make_item(FUNC_READ, 4'd4, 4'd8, 16'd0), 1'b0);
        send(make_item(FUNC_READ, 4'd0, 4'd0, 16'd0), 1'b0);
        send(make_item(FUNC_READ, 4'd15, 4'd0, 16'd0), 1'b0);
        send(make_item(FUNC_LOAD, 4'd2, 4'd9, 16'd0), 1'b0);
        send(make_item(FUNC_RUN, 4'hF, 4'hF, NOEDGE), 1'b0);
        send(make_item(FUNC_READ, 4'd2, 4'd9, 16'd0), 1'b0);

        runs_done = 0;
        sent      = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
            sel  = $urandom_range(0, 99);
            if (sel < 4 && runs_done < MAX_RANDOM_RUNS)
            begin
                send(make_item(FUNC_RUN, 4'($urandom), 4'($urandom), 16'($urandom)), calm);
                runs_done++;
                sent++;
            end
            else if (sel < 7)
            begin
                // ignored by the block, so it does not advance the count
                send(make_item(FUNC_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom)), calm);
            end
            else if (sel < 55)
            begin
                send(make_item(FUNC_LOAD, 4'($urandom), 4'($urandom), pick_weight()), calm);
                sent++;
            end
            else
            begin
                send(make_item(FUNC_READ, 4'($urandom), 4'($urandom), 16'($urandom)), calm);
                sent++;
            end
        end
        start <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
